/* hw/rtl/tbcl_pkg.sv */
// ----------------------------------------------------------------------------
// tbcl_pkg: shared types and constants of the two-button combination lock
// widths, register indexes, reset values and the structs passed between units
// ----------------------------------------------------------------------------
package tbcl_pkg;

    localparam int NumCodes          = 5;
    localparam int CodeWidth         = 8;
    localparam int TickWidth         = 8;
    localparam int PosWidth          = 3;
    localparam int CfgIdxWidth       = 3;
    localparam int DefaultCodeLength = 5;

    typedef logic signed [CodeWidth-1:0] t_code;
    typedef logic [TickWidth-1:0]        t_ticks;
    typedef logic [PosWidth-1:0]         t_pos;
    typedef logic [CfgIdxWidth-1:0]      t_cfg_idx;

    // register indexes on the configuration port
    localparam t_cfg_idx REG_CODE_0        = 3'd0;
    localparam t_cfg_idx REG_PRESS_TICKS   = 3'd5;
    localparam t_cfg_idx REG_RELEASE_TICKS = 3'd6;

    localparam t_code  CodeReset [NumCodes] = '{8'sd3, -8'sd3, 8'sd2, -8'sd1, 8'sd1};
    localparam t_ticks PressTicksReset   = 8'd10;
    localparam t_ticks ReleaseTicksReset = 8'd2;

    localparam t_code SumMax = 8'sd127;
    localparam t_code SumMin = -8'sd127;

    // debouncer outcome for one tick
    typedef struct packed {
        logic level;
        logic changed;
    } t_db_result;

    // combination sequencer outcome for one tick
    typedef struct packed {
        t_code sum_now;
        t_pos  position_now;
        logic  step_matched;
        logic  is_open;
        logic  opened;
        logic  closed;
    } t_lock_result;

    // one result item
    typedef struct packed {
        logic  left_level;
        logic  right_level;
        logic  left_changed;
        logic  right_changed;
        t_code sum_now;
        t_pos  position_now;
        logic  step_matched;
        logic  is_open;
        logic  opened;
        logic  closed;
    } t_result;

endpackage

/* hw/rtl/tbcl_if.sv */
// ----------------------------------------------------------------------------
// tbcl interfaces: input, result and configuration channels
// valid/ready channels, an item moves when both are high at a rising edge
// ----------------------------------------------------------------------------
interface tbcl_in_if;
    logic valid;
    logic ready;
    logic left_raw;
    logic right_raw;

    modport source (output valid, output left_raw, output right_raw, input ready);
    modport sink   (input valid, input left_raw, input right_raw, output ready);
endinterface

interface tbcl_res_if
    import tbcl_pkg::*;
;
    logic  valid;
    logic  ready;
    logic  left_level;
    logic  right_level;
    logic  left_changed;
    logic  right_changed;
    t_code sum_now;
    t_pos  position_now;
    logic  step_matched;
    logic  is_open;
    logic  opened;
    logic  closed;

    modport source (
        output valid, output left_level, output right_level, output left_changed,
        output right_changed, output sum_now, output position_now,
        output step_matched, output is_open, output opened, output closed,
        input ready
    );
    modport sink (
        input valid, input left_level, input right_level, input left_changed,
        input right_changed, input sum_now, input position_now,
        input step_matched, input is_open, input opened, input closed,
        output ready
    );
endinterface

interface tbcl_cfg_if
    import tbcl_pkg::*;
;
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_code    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/two_button_combination_lock.sv */
// ----------------------------------------------------------------------------
// two_button_combination_lock: debounced two-button combination lock
// per-button countdown debounce, press-step sum and code sequencer
// ----------------------------------------------------------------------------
//  channel     dir  handshake        payload
//  i_in_chan   in   valid / ready    left_raw, right_raw (one polling tick)
//  o_res_chan  out  valid / ready    debounced levels, sum, position, lock flags
//  i_cfg_chan  in   valid / ready    index (3 bit), data (8 bit)
//
//  one tick item per cycle while the sink keeps up: debounce and sequencer logic
//  sits between state and result registers, so throughput is one item per clock
//  the result register is a one-deep output stage; input ready stays high while
//  it is empty or being taken, so a stalled sink holds back exactly one item
//  i_rst_n (synchronous, active low) restores the reset codes and tick counts,
//  clears levels, sum, position and lock state and empties the result register
//  configuration writes are always taken (ready tied high); index 7 is ignored
// ----------------------------------------------------------------------------
module two_button_combination_lock
    import tbcl_pkg::*;
#(
    parameter int CODE_LENGTH = DefaultCodeLength
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tbcl_in_if.sink    i_in_chan,
    tbcl_res_if.source o_res_chan,
    tbcl_cfg_if.sink   i_cfg_chan
);

    localparam t_pos CodeLen = t_pos'(CODE_LENGTH);

    // configuration registers
    t_code  r_codes [NumCodes];
    t_ticks r_press_ticks;
    t_ticks r_release_ticks;

    // result register
    logic    r_out_valid;
    t_result r_result;

    logic         w_accept;
    t_db_result   w_left;
    t_db_result   w_right;
    t_lock_result w_lock;

    // --- configuration port ---
    assign i_cfg_chan.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes         <= CodeReset;
            r_press_ticks   <= PressTicksReset;
            r_release_ticks <= ReleaseTicksReset;
        end else if (i_cfg_chan.valid) begin
            priority if (i_cfg_chan.index < REG_PRESS_TICKS) begin
                // code entries sit from index zero upwards
                r_codes[i_cfg_chan.index - REG_CODE_0] <= i_cfg_chan.data;
            end else if (i_cfg_chan.index == REG_PRESS_TICKS) begin
                r_press_ticks <= t_ticks'(i_cfg_chan.data);
            end else if (i_cfg_chan.index == REG_RELEASE_TICKS) begin
                r_release_ticks <= t_ticks'(i_cfg_chan.data);
            end else begin
                // unmapped index, write dropped
            end
        end
    end

    // --- input handshake ---
    // take a tick while the result stage is empty or drains this cycle
    assign i_in_chan.ready = !r_out_valid || o_res_chan.ready;
    assign w_accept        = i_in_chan.valid && i_in_chan.ready;

    // --- debouncers, one per button ---
    tbcl_debounce u_db_left (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_raw           (i_in_chan.left_raw),
        .i_press_ticks   (r_press_ticks),
        .i_release_ticks (r_release_ticks),
        .o_result        (w_left)
    );

    tbcl_debounce u_db_right (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_raw           (i_in_chan.right_raw),
        .i_press_ticks   (r_press_ticks),
        .i_release_ticks (r_release_ticks),
        .o_result        (w_right)
    );

    // --- combination sequencer ---
    tbcl_seq #(
        .CODE_LENGTH (CODE_LENGTH)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_left   (w_left),
        .i_right  (w_right),
        .i_codes  (r_codes),
        .o_result (w_lock)
    );

    // --- result register ---
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res_chan.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= '{
                left_level:    w_left.level,
                right_level:   w_right.level,
                left_changed:  w_left.changed,
                right_changed: w_right.changed,
                sum_now:       w_lock.sum_now,
                position_now:  w_lock.position_now,
                step_matched:  w_lock.step_matched,
                is_open:       w_lock.is_open,
                opened:        w_lock.opened,
                closed:        w_lock.closed
            };
        end
    end

    assign o_res_chan.valid         = r_out_valid;
    assign o_res_chan.left_level    = r_result.left_level;
    assign o_res_chan.right_level   = r_result.right_level;
    assign o_res_chan.left_changed  = r_result.left_changed;
    assign o_res_chan.right_changed = r_result.right_changed;
    assign o_res_chan.sum_now       = r_result.sum_now;
    assign o_res_chan.position_now  = r_result.position_now;
    assign o_res_chan.step_matched  = r_result.step_matched;
    assign o_res_chan.is_open       = r_result.is_open;
    assign o_res_chan.opened        = r_result.opened;
    assign o_res_chan.closed        = r_result.closed;

    // --- assertions ---
    // opening always comes from a final match and leaves a cleared entry
    a_open_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.opened) |->
            (r_result.step_matched && r_result.is_open
             && (r_result.position_now == '0) && (r_result.sum_now == '0)))
        else $error("open without final match or cleared entry");

    // a close or a match needs a press on this tick
    a_needs_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_result.closed || r_result.step_matched)) |->
            ((r_result.left_changed && r_result.left_level)
             || (r_result.right_changed && r_result.right_level)))
        else $error("close or match without a press");

    // position stays inside the combination
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_result.position_now < CodeLen))
        else $error("position beyond code length");

    // saturation keeps the sum off -128
    a_sum_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_result.sum_now != -8'sd128))
        else $error("entry sum left the saturation range");

endmodule

/* hw/rtl/tbcl_debounce.sv */
// ----------------------------------------------------------------------------
// tbcl_debounce: countdown debouncer for one button
// reloads while raw matches the debounced level, counts down while it differs
// ----------------------------------------------------------------------------
module tbcl_debounce
    import tbcl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_raw,
    input  t_ticks     i_press_ticks,
    input  t_ticks     i_release_ticks,
    output t_db_result o_result
);

    logic   r_level;
    t_ticks r_count;
    logic   n_level;
    t_ticks n_count;
    t_ticks w_dec;

    assign w_dec = r_count - 8'd1;

    always_comb begin
        n_level  = r_level;
        n_count  = r_count;
        o_result = '{level: r_level, changed: 1'b0};
        if (i_raw == r_level) begin
            n_count = r_level ? i_release_ticks : i_press_ticks;
        end else if (w_dec == '0) begin
            // new level accepted, reload for it
            n_level  = i_raw;
            n_count  = i_raw ? i_release_ticks : i_press_ticks;
            o_result = '{level: i_raw, changed: 1'b1};
        end else begin
            n_count = w_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= 1'b0;
            r_count <= PressTicksReset;
        end else if (i_accept) begin
            r_level <= n_level;
            r_count <= n_count;
        end
    end

endmodule

/* hw/rtl/tbcl_seq.sv */
// ----------------------------------------------------------------------------
// tbcl_seq: combination sequencer
// running sum of press steps, code position and lock state
// ----------------------------------------------------------------------------
module tbcl_seq
    import tbcl_pkg::*;
#(
    parameter int CODE_LENGTH = DefaultCodeLength
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_accept,
    input  t_db_result   i_left,
    input  t_db_result   i_right,
    input  t_code        i_codes [NumCodes],
    output t_lock_result o_result
);

    localparam t_pos CodeLen     = t_pos'(CODE_LENGTH);
    localparam t_pos NumCodesPos = t_pos'(NumCodes);

    t_code r_sum;
    t_pos  r_idx;
    logic  r_open;
    t_code n_sum;
    t_pos  n_idx;
    logic  n_open;

    logic                  w_press;
    logic signed [CodeWidth:0] w_step;
    logic signed [CodeWidth:0] w_sum_ext;
    t_code                 w_sum_sat;
    t_code                 w_code_sel;
    logic                  w_match;
    t_pos                  w_idx_after;
    logic                  w_opened;

    assign w_press = (i_left.changed & i_left.level) | (i_right.changed & i_right.level);

    always_comb begin
        priority if (i_left.level && !i_right.level) begin
            w_step = -9'sd1;
        end else if (!i_left.level && i_right.level) begin
            w_step = 9'sd1;
        end else begin
            w_step = '0;
        end
    end

    assign w_sum_ext = {r_sum[CodeWidth-1], r_sum} + w_step;

    // saturate at +/-127
    always_comb begin
        priority if (w_sum_ext > 9'sd127) begin
            w_sum_sat = SumMax;
        end else if (w_sum_ext < -9'sd127) begin
            w_sum_sat = SumMin;
        end else begin
            w_sum_sat = w_sum_ext[CodeWidth-1:0];
        end
    end

    always_comb begin
        if (r_idx < NumCodesPos) begin
            w_code_sel = i_codes[r_idx];
        end else begin
            w_code_sel = '0;
        end
    end

    assign w_match     = w_press && (r_idx < CodeLen) && (r_idx < NumCodesPos)
                         && (w_code_sel == w_sum_sat);
    assign w_idx_after = w_match ? t_pos'(r_idx + 3'd1) : r_idx;
    assign w_opened    = w_press && (w_idx_after == CodeLen);

    always_comb begin
        n_sum  = r_sum;
        n_idx  = r_idx;
        n_open = r_open;
        if (w_press) begin
            n_sum  = (w_match || w_opened) ? '0 : w_sum_sat;
            n_idx  = w_opened ? '0 : w_idx_after;
            n_open = w_opened;
        end
    end

    assign o_result = '{
        sum_now:      n_sum,
        position_now: n_idx,
        step_matched: w_match,
        is_open:      n_open,
        opened:       w_opened,
        closed:       w_press & r_open
    };

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_idx  <= '0;
            r_open <= 1'b0;
        end else if (i_accept) begin
            r_sum  <= n_sum;
            r_idx  <= n_idx;
            r_open <= n_open;
        end
    end

endmodule
